// ===== design/swm_pkg.sv =====
// Package: shared widths, defaults and divider status type for the sliding window mean.
package swm_pkg;

   localparam int SAMPLE_W       = 32;
   localparam int MEAN_W         = 32;
   localparam int WINDOW_DEFAULT = 16;

   typedef struct packed {
      logic busy;
      logic done;
   } swm_div_status_type;

endpackage

// ===== design/swm_divider.sv =====
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
module swm_divider #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DIVIDEND_W-1:0]           dividend,
   input  logic [DIVISOR_W-1:0]            divisor,
   output swm_pkg::swm_div_status_type     status,
   output logic [DIVIDEND_W-1:0]           quotient
);
   import swm_pkg::*;

   localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = STEP_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== design/sliding_window_mean.sv =====
// Top level: moving average over the last WINDOW samples, ring store in a synchronous memory.
//
//   channel   dir   payload (low bit up)                                   handshake
//   req_      in    tdata: sample[31:0]                                    tvalid/tready
//   rsp_      out   tdata: window_mean[31:0], samples_held, window_full    tvalid/tready
//
// One word at a time: after accept the FSM steps through S_UPDATE, S_PREP, S_DIV and S_DONE, with
// the one-bit-per-cycle divider forming sum / count in S_DIV; the result is then registered.
// The oldest sample is read from the ring memory in the accept cycle; the new sample is written next.
// Reset clears fill count, oldest slot and running sum; the memory holds no reset value.
// A stalled result sits in the output register; the next word is taken meanwhile.
module sliding_window_mean #(
   parameter int WINDOW = swm_pkg::WINDOW_DEFAULT,
   parameter int CNT_W  = $clog2(WINDOW + 1),
   parameter int OUT_W  = ((swm_pkg::MEAN_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [swm_pkg::SAMPLE_W-1:0] req_tdata,   // sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [OUT_W-1:0]             rsp_tdata    // window_mean, samples_held, window_full
);
   import swm_pkg::*;

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_UPDATE = 5'b00010,
      S_PREP   = 5'b00100,
      S_DIV    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SAMPLE_W-1:0] sample_store [WINDOW];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic        [CNT_W-1:0]    count_ff, count_in;
   logic        [IDX_W-1:0]    oldest_ff, oldest_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic        [OUT_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       req_accept;
   logic                       full;
   logic                       mem_we;
   logic        [IDX_W-1:0]    wr_addr;
   logic signed [SAMPLE_W-1:0] leaving;
   logic        [SUM_W-1:0]    sum_mag;
   logic                       div_start;
   swm_div_status_type         div_status;
   logic        [SUM_W-1:0]    quotient;
   logic        [MEAN_W-1:0]   mean;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(WINDOW));
   assign mem_we     = (state_ff == S_UPDATE);
   assign wr_addr    = full ? oldest_ff : count_ff[IDX_W-1:0];
   assign leaving    = full ? rd_data_ff : '0;
   assign div_start  = (state_ff == S_PREP);
   assign sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mean       = sum_ff[SUM_W-1] ? MEAN_W'(-quotient[MEAN_W-1:0]) : quotient[MEAN_W-1:0];

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[wr_addr] <= sample_ff;
      end
      if (req_accept) begin
         rd_data_ff <= sample_store[oldest_ff];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            sum_in = sum_ff - SUM_W'(leaving) + SUM_W'(sample_ff);
            if (full) begin
               oldest_in = (oldest_ff == IDX_W'(WINDOW - 1)) ? '0 : oldest_ff + IDX_W'(1);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_PREP;
         end
         S_PREP: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[MEAN_W-1:0]      = mean;
               rsp_data_in[MEAN_W +: CNT_W] = count_ff;
               rsp_data_in[MEAN_W + CNT_W]  = full;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         sample_ff <= req_tdata;
      end
   end

   swm_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/swm_checker.sv =====
// Port-level checker for the sliding window mean, bound to the top level.
module swm_checker #(
   parameter int WINDOW = swm_pkg::WINDOW_DEFAULT,
   parameter int CNT_W  = $clog2(WINDOW + 1),
   parameter int OUT_W  = ((swm_pkg::MEAN_W + CNT_W + 1 + 7) / 8) * 8
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [swm_pkg::SAMPLE_W-1:0] req_tdata,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [OUT_W-1:0]             rsp_tdata
);
   import swm_pkg::*;

   logic [CNT_W-1:0] held;
   logic             full_flag;

   assign held      = rsp_tdata[MEAN_W +: CNT_W];
   assign full_flag = rsp_tdata[MEAN_W + CNT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a word is in work");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (held != '0) && (held <= CNT_W'(WINDOW)))
      else $error("sample count out of range");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (full_flag == (held == CNT_W'(WINDOW))))
      else $error("full flag disagrees with count");

endmodule

bind sliding_window_mean swm_checker #(.WINDOW(WINDOW)) u_swm_checker (.*);

// ===== dv/sliding_window_mean_tb.sv =====
// Testbench: streams samples into sliding_window_mean and checks every mean word.
module sliding_window_mean_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN            = swm_pkg::WINDOW_DEFAULT;
   localparam int MEAN_W         = swm_pkg::MEAN_W;
   localparam int CNT_W          = $clog2(WIN + 1);
   localparam int OUT_W          = ((MEAN_W + CNT_W + 1 + 7) / 8) * 8;
   localparam int N_DIRECTED     = 24;
   localparam int N_RANDOM       = 1000;
   localparam int N_QUIET        = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [CNT_W-1:0]  held;
      logic              full;
   } mean_word_t;

   typedef struct packed {
      logic [swm_pkg::SAMPLE_W-1:0] sample;
      logic                         hand_checked;
      mean_word_t                   exp_word;
   } stim_row_t;

   typedef enum int {
      MIX_RANDOM,
      MIX_SMALL,
      MIX_TOP,
      MIX_BOTTOM,
      MIX_SWING,
      MIX_TRACK
   } sample_mix_t;

   bit clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [swm_pkg::SAMPLE_W-1:0] req_tdata = '0;   // sample
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;                    // window_mean, samples_held, window_full

   sliding_window_mean u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // window model
   int     win_store [WIN];
   int     win_count  = 0;
   int     win_oldest = 0;
   longint win_sum    = 0;

   mean_word_t mean_queue [$];

   int  errors        = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  full_words    = 0;
   int  neg_words     = 0;
   int  stall_cycles  = 0;
   bit  quiet         = 1'b0;
   bit  swing_hi      = 1'b0;
   int  track_pos     = 0;

   // extremes first, then a fill to WINDOW and a few overwrites
   stim_row_t directed_rows [N_DIRECTED] = '{
      '{32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 5'd1, 1'b0}},
      '{32'h8000_0000, 1'b1, '{32'h0000_0000, 5'd2, 1'b0}},
      '{32'hFFFF_FFFD, 1'b0, '0},
      '{32'h0000_0001, 1'b0, '0},
      '{32'h0000_0000, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'h0000_0007, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h0000_0010, 1'b0, '0},
      '{32'hFFFF_FFF0, 1'b0, '0},
      '{32'h1AFE_6C80, 1'b0, '0},
      '{32'hE50A_0B00, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h0000_0000, 1'b0, '0},
      '{32'hFFFF_FFFF, 1'b0, '0},
      '{32'h1234_5678, 1'b0, '0},
      '{32'h8765_4321, 1'b0, '0},
      '{32'h0000_000F, 1'b0, '0},
      '{32'hF000_0000, 1'b0, '0}
   };

   function automatic mean_word_t advance_window(input logic [swm_pkg::SAMPLE_W-1:0] raw);
      int         s;
      longint     q;
      mean_word_t w;
      s = int'(raw);
      if (win_count < WIN) begin
         win_store[win_count] = s;
         win_count++;
         win_sum += longint'(s);
      end else begin
         win_sum -= longint'(win_store[win_oldest]);
         win_store[win_oldest] = s;
         win_sum += longint'(s);
         win_oldest = (win_oldest == WIN - 1) ? 0 : win_oldest + 1;
      end
      q      = win_sum / longint'(win_count);
      w.mean = q[MEAN_W-1:0];
      w.held = win_count[CNT_W-1:0];
      w.full = (win_count == WIN);
      return w;
   endfunction

   function automatic logic [31:0] pick_sample(input sample_mix_t mix);
      int v;
      v = 0;
      case (mix)
         MIX_RANDOM: v = int'($urandom);
         MIX_SMALL:  v = int'($urandom_range(0, 40)) - 20;
         MIX_TOP:    v = 32'h7FFF_FFFF;
         MIX_BOTTOM: v = 32'h8000_0000;
         MIX_SWING: begin
            swing_hi = ~swing_hi;
            v = swing_hi ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         default: begin
            track_pos += int'($urandom_range(0, 2000)) - 1000;
            v = track_pos;
         end
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic [31:0] s, input logic hand_checked,
                              input mean_word_t hand_word);
      int         gap;
      mean_word_t w;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock) req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      w = advance_window(s);
      if (hand_checked) w = hand_word;
      mean_queue.push_back(w);
      words_sent++;
   endtask

   initial begin
      int          seg_left;
      sample_mix_t mix;
      int          pick;
      seg_left = 0;
      mix      = MIX_RANDOM;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].hand_checked,
                     directed_rows[i].exp_word);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n >= N_RANDOM - N_QUIET) quiet = 1'b1;
         if (seg_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      mix = MIX_RANDOM;
            else if (pick < 65) mix = MIX_TRACK;
            else if (pick < 80) mix = MIX_SMALL;
            else if (pick < 87) mix = MIX_TOP;
            else if (pick < 94) mix = MIX_BOTTOM;
            else                mix = MIX_SWING;
            if (mix == MIX_TOP || mix == MIX_BOTTOM) seg_left = $urandom_range(WIN, 2 * WIN);
            else seg_left = $urandom_range(1, 40);
            if (mix == MIX_TRACK) begin
               track_pos = int'($urandom_range(0, 1800000000));
               if ($urandom_range(0, 1)) track_pos = -track_pos;
            end
         end
         send_sample(pick_sample(mix), 1'b0, '0);
         seg_left--;
      end
      @(negedge clock) req_tvalid = 1'b0;

      while (mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mean_queue.size() != 0) begin
         $error("%0d mean words never arrived", mean_queue.size());
         errors++;
      end
      $display("sent %0d samples, checked %0d mean words", words_sent, words_checked);
      $display("%0d words with a full window, %0d with a negative mean", full_words, neg_words);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // result side backpressure
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (quiet) begin
            @(negedge clock) rsp_tready = 1'b1;
         end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            repeat (n) @(negedge clock) rsp_tready = 1'b1;
            if ($urandom_range(0, 2) != 0) begin
               n = $urandom_range(1, 13);
               repeat (n) @(negedge clock) rsp_tready = 1'b0;
            end
         end
      end
   end

   mean_word_t seen_word, due_word;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_word.mean = rsp_tdata[MEAN_W-1:0];
         seen_word.held = rsp_tdata[MEAN_W +: CNT_W];
         seen_word.full = rsp_tdata[MEAN_W + CNT_W];
         if (mean_queue.size() == 0) begin
            $error("unexpected mean word %h", rsp_tdata);
            errors++;
         end else begin
            due_word = mean_queue.pop_front();
            words_checked++;
            if (due_word.full) full_words++;
            if (due_word.mean[MEAN_W-1]) neg_words++;
            if (seen_word.mean !== due_word.mean) begin
               $error("window_mean: expected %0d, got %0d",
                      $signed(due_word.mean), $signed(seen_word.mean));
               errors++;
            end
            if (seen_word.held !== due_word.held) begin
               $error("samples_held: expected %0d, got %0d", due_word.held, seen_word.held);
               errors++;
            end
            if (seen_word.full !== due_word.full) begin
               $error("window_full: expected %0d, got %0d", due_word.full, seen_word.full);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
